[hdl/udp_port_payload_extractor_unit_defines.svh]
// ----------------------------------------------------------------------------
// UDP port payload extractor - assertion macros
// Property wrappers for the port checker file.
// ----------------------------------------------------------------------------
`ifndef UDP_PORT_PAYLOAD_EXTRACTOR_UNIT_DEFINES_SVH
`define UDP_PORT_PAYLOAD_EXTRACTOR_UNIT_DEFINES_SVH

// same-cycle implication, ignored while reset is asserted
`define UDPPX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("udppx checker: same-cycle property violated");

// next-cycle implication, ignored while reset is asserted
`define UDPPX_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("udppx checker: next-cycle property violated");

// next-cycle implication, checked through reset as well
`define UDPPX_ASSERT_NXT_NR(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("udppx checker: reset property violated");

`endif

[hdl/udppx_pkg.sv]
// ----------------------------------------------------------------------------
// UDP port payload extractor - package
// Widths, protocol constants, register indexes and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package udppx_pkg;

    // parameter defaults
    localparam int MSG_CHARS_DEF = 32;
    localparam int MAX_FRAME_DEF = 2048;

    // stream and register port widths
    localparam int BYTE_W     = 8;
    localparam int IDX_OUT_W  = 6;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int POS_W      = 16;
    localparam int IHL_BYTES_W = 6;

    // register index, taken from paddr[2]
    localparam logic REG_MATCH_PORT = 1'b0;
    localparam logic REG_CAPTURE_EN = 1'b1;

    // frame layout and protocol values
    localparam logic [POS_W-1:0] ETH_HDR_BYTES  = 16'd14;
    localparam logic [POS_W-1:0] POS_ETYPE_LO   = 16'd13;
    localparam logic [POS_W-1:0] POS_IP_PROTO   = 16'd23;
    localparam logic [POS_W-1:0] UDP_PORT_OFS   = 16'd3;
    localparam logic [POS_W-1:0] UDP_LEN_OFS    = 16'd5;
    localparam logic [POS_W-1:0] UDP_HDR_BYTES  = 16'd8;
    localparam logic [POS_W-1:0] POS_SATURATED  = 16'hFFFF;
    localparam logic [15:0]      ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]       IP_PROTO_UDP   = 8'd17;
    localparam logic [7:0]       PAD_CHAR       = 8'h20;

endpackage

`default_nettype wire

[hdl/udp_port_payload_extractor_unit.sv]
// ----------------------------------------------------------------------------
// UDP port payload extractor
// Parses Ethernet/IPv4/UDP frames byte by byte and emits the payload of
// frames sent to a chosen UDP port as a fixed-length, space-padded message.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Content
//  ---------+-----------+---------------------------------------------------
//  s_       | in        | one frame byte per transfer, tlast on final byte
//  m_       | out       | one message character per transfer, tlast on final
//  apb      | in/out    | match_port at 0x0, capture_enable at 0x4
//
//  One frame byte is taken per cycle while s_tready is high. A matching
//  frame yields MSG_CHARS characters, one per cycle while m_tready is high;
//  the first passes the bank swap and the memory read register to the output register.
//  Payload is written into one half of a two-bank message memory while the
//  other half is read out, so the final byte of a frame waits (s_tready low)
//  only while the previous message is still being read from the memory.
//  Reset is synchronous, active low; m_tready low holds the output register.
//
`default_nettype none

module udp_port_payload_extractor_unit #(
    parameter int MSG_CHARS = udppx_pkg::MSG_CHARS_DEF,
    parameter int MAX_FRAME = udppx_pkg::MAX_FRAME_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [udppx_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] frame_byte
    input  wire logic                                s_tlast,
    // result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [udppx_pkg::M_TDATA_W-1:0]          m_tdata,   // [7:0] text_char,
                                                                // [13:8] char_index,
                                                                // [15:14] zero
    output logic                                     m_tlast,
    // configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [udppx_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [udppx_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [udppx_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                     pready
);

    localparam int IDX_W     = (MSG_CHARS > 1) ? $clog2(MSG_CHARS) : 1;
    localparam int CNT_W     = $clog2(MSG_CHARS + 1);
    localparam int CMP_W     = IDX_W + 1;
    localparam int MEM_DEPTH = 2 ** (IDX_W + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MSG_CHARS - 1);
    localparam logic [udppx_pkg::POS_W-1:0] MAX_POS   = udppx_pkg::POS_W'(MAX_FRAME);
    localparam logic [udppx_pkg::POS_W-1:0] MSG_LIMIT = udppx_pkg::POS_W'(MSG_CHARS);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [15:0] match_port_reg;
    logic        capture_en_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_port_reg <= '0;
            capture_en_reg <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[2])
                udppx_pkg::REG_MATCH_PORT: match_port_reg <= pwdata[15:0];
                udppx_pkg::REG_CAPTURE_EN: capture_en_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr[2])
            udppx_pkg::REG_MATCH_PORT: prdata[15:0] = match_port_reg;
            udppx_pkg::REG_CAPTURE_EN: prdata[0]    = capture_en_reg;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // frame parser state
    // ------------------------------------------------------------------
    logic [udppx_pkg::POS_W-1:0]       pos_reg;
    logic [7:0]                        held_byte_reg;
    logic                              ipv4_reg;
    logic                              udp_reg;
    logic [udppx_pkg::IHL_BYTES_W-1:0] ihl_reg;
    logic [15:0]                       udp_len_reg;
    logic                              port_hit_reg;
    logic                              rejected_reg;
    logic [CNT_W-1:0]                  cap_cnt_reg;

    logic [udppx_pkg::POS_W-1:0]       pos_next;
    logic                              ipv4_next;
    logic                              udp_next;
    logic [udppx_pkg::IHL_BYTES_W-1:0] ihl_next;
    logic [15:0]                       udp_len_next;
    logic                              port_hit_next;
    logic                              rejected_next;
    logic [CNT_W-1:0]                  cap_cnt_next;

    logic [15:0]                 word;
    logic [udppx_pkg::POS_W-1:0] udp_base;
    logic [udppx_pkg::POS_W-1:0] pay_base;
    logic [udppx_pkg::POS_W-1:0] pay_off;
    logic [udppx_pkg::POS_W-1:0] pay_len;
    logic                        past_eth;
    logic                        in_payload;
    logic                        frame_match;
    logic [CNT_W-1:0]            valid_cnt;
    logic                        in_xfer;
    logic                        launch;

    // emitter state
    logic             emit_busy_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             wr_bank_reg;
    logic             rd_bank_reg;
    logic [CNT_W-1:0] valid_cnt_reg;

    // stall only the closing byte, and only while the read bank is still busy
    assign s_tready = ~(emit_busy_reg & s_tvalid & s_tlast);
    assign in_xfer  = s_tvalid & s_tready;

    always_comb begin
        word       = {held_byte_reg, s_tdata};
        udp_base   = udppx_pkg::ETH_HDR_BYTES + udppx_pkg::POS_W'(ihl_reg);
        pay_base   = udp_base + udppx_pkg::UDP_HDR_BYTES;
        pay_off    = pos_reg - pay_base;
        past_eth   = pos_reg > udppx_pkg::ETH_HDR_BYTES;
        in_payload = past_eth && (pos_reg >= pay_base) && (pay_off < MSG_LIMIT);

        rejected_next = rejected_reg
                      | ((pos_reg == '0) & ~capture_en_reg)
                      | (pos_reg >= MAX_POS);
        ipv4_next = (pos_reg == udppx_pkg::POS_ETYPE_LO)
                  ? (word == udppx_pkg::ETHERTYPE_IPV4) : ipv4_reg;
        ihl_next  = (pos_reg == udppx_pkg::ETH_HDR_BYTES)
                  ? {s_tdata[3:0], 2'b00} : ihl_reg;
        udp_next  = (pos_reg == udppx_pkg::POS_IP_PROTO)
                  ? (s_tdata == udppx_pkg::IP_PROTO_UDP) : udp_reg;
        port_hit_next = (past_eth && pos_reg == udp_base + udppx_pkg::UDP_PORT_OFS)
                      ? (word == match_port_reg) : port_hit_reg;
        udp_len_next  = (past_eth && pos_reg == udp_base + udppx_pkg::UDP_LEN_OFS)
                      ? word : udp_len_reg;
        cap_cnt_next  = in_payload ? CNT_W'(pay_off + 16'd1) : cap_cnt_reg;
        pos_next      = (pos_reg == udppx_pkg::POS_SATURATED) ? pos_reg : pos_reg + 16'd1;

        frame_match = s_tlast & ~rejected_next & ipv4_next & udp_next & port_hit_next;

        // payload bytes to show: min(udp length - header, bytes captured)
        pay_len   = (udp_len_next >= udppx_pkg::UDP_HDR_BYTES)
                  ? udp_len_next - udppx_pkg::UDP_HDR_BYTES : '0;
        valid_cnt = (pay_len > udppx_pkg::POS_W'(cap_cnt_next))
                  ? cap_cnt_next : CNT_W'(pay_len);
    end

    assign launch = in_xfer & frame_match;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            held_byte_reg <= '0;
            ipv4_reg      <= 1'b0;
            udp_reg       <= 1'b0;
            ihl_reg       <= '0;
            udp_len_reg   <= '0;
            port_hit_reg  <= 1'b0;
            rejected_reg  <= 1'b0;
            cap_cnt_reg   <= '0;
        end else if (in_xfer) begin
            if (s_tlast) begin
                // end of frame: start the next one from scratch
                pos_reg       <= '0;
                held_byte_reg <= '0;
                ipv4_reg      <= 1'b0;
                udp_reg       <= 1'b0;
                ihl_reg       <= '0;
                udp_len_reg   <= '0;
                port_hit_reg  <= 1'b0;
                rejected_reg  <= 1'b0;
                cap_cnt_reg   <= '0;
            end else begin
                pos_reg       <= pos_next;
                held_byte_reg <= s_tdata;
                ipv4_reg      <= ipv4_next;
                udp_reg       <= udp_next;
                ihl_reg       <= ihl_next;
                udp_len_reg   <= udp_len_next;
                port_hit_reg  <= port_hit_next;
                rejected_reg  <= rejected_next;
                cap_cnt_reg   <= cap_cnt_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // two-bank message memory
    // ------------------------------------------------------------------
    logic [7:0] msg_mem [MEM_DEPTH];
    logic [7:0] rd_data_reg;
    logic       issue;
    logic       load_now;

    logic             pend_reg;
    logic [IDX_W-1:0] pend_idx_reg;
    logic             pend_pad_reg;
    logic             pend_last_reg;

    logic                            m_valid_reg;
    logic [7:0]                      m_char_reg;
    logic [udppx_pkg::IDX_OUT_W-1:0] m_idx_reg;
    logic                            m_last_reg;

    always_ff @(posedge aclk) begin
        if (in_xfer && in_payload) begin
            msg_mem[{wr_bank_reg, pay_off[IDX_W-1:0]}] <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_data_reg <= msg_mem[{rd_bank_reg, idx_reg}];
        end
    end

    // ------------------------------------------------------------------
    // message read-out
    // ------------------------------------------------------------------
    assign load_now = pend_reg & (~m_valid_reg | m_tready);
    assign issue    = emit_busy_reg & (~pend_reg | load_now);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_busy_reg <= 1'b0;
            idx_reg       <= '0;
            wr_bank_reg   <= 1'b0;
            rd_bank_reg   <= 1'b0;
            valid_cnt_reg <= '0;
        end else if (launch) begin
            // swap banks: the finished message becomes the read bank
            emit_busy_reg <= 1'b1;
            idx_reg       <= '0;
            rd_bank_reg   <= wr_bank_reg;
            wr_bank_reg   <= ~wr_bank_reg;
            valid_cnt_reg <= valid_cnt;
        end else if (issue) begin
            idx_reg <= idx_reg + 1'b1;
            if (idx_reg == LAST_IDX) begin
                emit_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else if (issue) begin
            pend_reg <= 1'b1;
        end else if (load_now) begin
            pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            pend_idx_reg  <= idx_reg;
            pend_pad_reg  <= CMP_W'(idx_reg) >= CMP_W'(valid_cnt_reg);
            pend_last_reg <= idx_reg == LAST_IDX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_now) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_now) begin
            m_char_reg <= pend_pad_reg ? udppx_pkg::PAD_CHAR : rd_data_reg;
            m_idx_reg  <= udppx_pkg::IDX_OUT_W'(pend_idx_reg);
            m_last_reg <= pend_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_idx_reg, m_char_reg};
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

[hdl/udppx_checker.sv]
// ----------------------------------------------------------------------------
// UDP port payload extractor - port checker
// Watches the stream ports of the extractor and flags illegal behaviour.
// ----------------------------------------------------------------------------
`default_nettype none

`include "udp_port_payload_extractor_unit_defines.svh"

module udppx_checker #(
    parameter int MSG_CHARS = udppx_pkg::MSG_CHARS_DEF
) (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            s_tlast,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [udppx_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                            m_tlast
);

    localparam logic [udppx_pkg::IDX_OUT_W-1:0] LAST_IDX =
        udppx_pkg::IDX_OUT_W'(MSG_CHARS - 1);

    // a stalled character holds
    `UDPPX_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // nothing is offered straight after reset
    `UDPPX_ASSERT_NXT_NR(a_out_reset, aclk, !aresetn, !m_tvalid)

    // input back-pressure only on the closing byte of a frame
    `UDPPX_ASSERT_IMP(a_in_stall, aclk, aresetn, !s_tready, s_tvalid && s_tlast)

    // message closes at the last position
    `UDPPX_ASSERT_IMP(a_last_idx, aclk, aresetn, m_tvalid && m_tlast, m_tdata[13:8] == LAST_IDX)

    // characters of a message follow without gaps, in order
    `UDPPX_ASSERT_NXT(a_idx_step, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tdata[13:8] == 6'($past(m_tdata[13:8]) + 6'd1)))

endmodule

bind udp_port_payload_extractor_unit udppx_checker #(
    .MSG_CHARS (MSG_CHARS)
) u_udppx_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

[test/udp_payload_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UDP payload extractor - stream checker
// Follows the register port and every frame byte transfer, predicts the
// message characters of each matching frame and compares them, in order,
// with the transfers that leave the result stream.
// ----------------------------------------------------------------------------
module udp_payload_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [udppx_pkg::S_TDATA_W-1:0]     s_tdata,    // [7:0] frame_byte
    input  logic                                s_tlast,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [udppx_pkg::M_TDATA_W-1:0]     m_tdata,    // [7:0] text_char,
                                                            // [13:8] char_index,
                                                            // [15:14] zero
    input  logic                                m_tlast,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [udppx_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [udppx_pkg::APB_DATA_W-1:0]    pwdata,
    input  logic                                pready,
    output int                                  mismatches,
    output int                                  chars_pending
);

    import udppx_pkg::*;

    localparam int MSG_CHARS = MSG_CHARS_DEF;
    localparam int MAX_FRAME = MAX_FRAME_DEF;

    typedef struct packed {
        logic [7:0]           ch;
        logic [IDX_OUT_W-1:0] idx;
        logic                 last;
    } message_char_t;

    message_char_t expected_chars[$];

    // register copy
    logic [15:0]            cfg_port;
    logic                   cfg_enable;

    // per-frame parse state
    logic [POS_W-1:0]       pos_count;
    logic [7:0]             prev_byte;
    logic                   ipv4_seen;
    logic                   udp_seen;
    logic [IHL_BYTES_W-1:0] ihl_bytes;
    logic [15:0]            udp_len;
    logic                   port_hit;
    logic                   frame_dropped;
    logic [6:0]             payload_count;
    logic [7:0]             payload_buf [MSG_CHARS];

    task automatic clear_frame_state();
        pos_count     = '0;
        prev_byte     = '0;
        ipv4_seen     = 1'b0;
        udp_seen      = 1'b0;
        ihl_bytes     = '0;
        udp_len       = '0;
        port_hit      = 1'b0;
        frame_dropped = 1'b0;
        payload_count = '0;
    endtask

    task automatic parse_frame_byte(input logic [7:0] b, input logic last);
        int            pos;
        int            udp_base;
        int            pay_base;
        int            valid;
        logic [15:0]   word;
        message_char_t c;
        pos      = pos_count;
        udp_base = ETH_HDR_BYTES + ihl_bytes;
        pay_base = udp_base + UDP_HDR_BYTES;
        word     = {prev_byte, b};

        // enable is looked at on the first byte only
        if (pos == 0 && !cfg_enable)
            frame_dropped = 1'b1;
        if (pos >= MAX_FRAME)
            frame_dropped = 1'b1;

        if (pos == POS_ETYPE_LO)
            ipv4_seen = (word == ETHERTYPE_IPV4);
        if (pos == ETH_HDR_BYTES)
            ihl_bytes = {b[3:0], 2'b00};
        if (pos == POS_IP_PROTO)
            udp_seen = (b == IP_PROTO_UDP);
        // UDP fields sit at fixed offsets, even when they overlap the IP header
        if (pos > ETH_HDR_BYTES) begin
            if (pos == udp_base + UDP_PORT_OFS)
                port_hit = (word == cfg_port);
            if (pos == udp_base + UDP_LEN_OFS)
                udp_len = word;
            if (pos >= pay_base && pos - pay_base < MSG_CHARS) begin
                payload_buf[pos - pay_base] = b;
                payload_count = 7'(pos - pay_base + 1);
            end
        end

        prev_byte = b;
        if (pos_count != POS_SATURATED)
            pos_count = pos_count + 1'b1;

        if (last) begin
            if (!frame_dropped && ipv4_seen && udp_seen && port_hit) begin
                valid = (udp_len >= UDP_HDR_BYTES) ? udp_len - UDP_HDR_BYTES : 0;
                if (valid > payload_count)
                    valid = payload_count;
                for (int k = 0; k < MSG_CHARS; k++) begin
                    c.ch   = (k < valid) ? payload_buf[k] : PAD_CHAR;
                    c.idx  = IDX_OUT_W'(k);
                    c.last = (k == MSG_CHARS - 1);
                    expected_chars.push_back(c);
                end
            end
            clear_frame_state();
        end
    endtask

    always @(posedge aclk) begin
        message_char_t want;
        if (!aresetn) begin
            cfg_port   = '0;
            cfg_enable = 1'b0;
            mismatches = 0;
            clear_frame_state();
            expected_chars.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[2])
                    REG_MATCH_PORT: cfg_port   = pwdata[15:0];
                    REG_CAPTURE_EN: cfg_enable = pwdata[0];
                    default: ;
                endcase
            end
            // compare before predicting: a result never shares the edge of its frame end
            if (m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected character transfer: tdata %h tlast %b",
                           m_tdata, m_tlast);
                    mismatches++;
                end else begin
                    want = expected_chars.pop_front();
                    if (m_tdata[7:0] !== want.ch) begin
                        $error("text_char: expected %h, actual %h", want.ch, m_tdata[7:0]);
                        mismatches++;
                    end
                    if (m_tdata[13:8] !== want.idx) begin
                        $error("char_index: expected %0d, actual %0d",
                               want.idx, m_tdata[13:8]);
                        mismatches++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("text_last: expected %b, actual %b", want.last, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                parse_frame_byte(s_tdata, s_tlast);
        end
        chars_pending = expected_chars.size();
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UDP payload extractor - testbench
// Configures the port filter over the register bus, sends directed frames
// (capture disabled, a normal match, a short UDP length), then random
// well-formed, broken and noise frames with random input gaps and output back-pressure.
// ----------------------------------------------------------------------------
module testbench;

    import udppx_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int ITEM_TARGET  = 150;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;     // [7:0] frame_byte
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;     // [7:0] text_char, [13:8] char_index, [15:14] zero
    logic                  m_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    mismatches;
    int                    chars_pending;
    int                    cycle_count = 0;
    int                    bytes_sent = 0;
    bit                    steady_flow = 1'b0;
    logic [15:0]           cur_port;
    logic [7:0]            frame_q[$];

    udp_port_payload_extractor_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    udp_payload_checker char_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .mismatches    (mismatches),
        .chars_pending (chars_pending)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic bit take_gap();
        return !steady_flow && ($urandom_range(0, 99) < 24);
    endfunction

    always @(negedge aclk)
        m_tready <= !take_gap();

    function automatic void put_byte(int pos, logic [7:0] val);
        if (pos < frame_q.size())
            frame_q[pos] = val;
    endfunction

    // total of zero means the natural length: headers plus payload
    function automatic void build_frame(logic [15:0] etype, int ihl, logic [7:0] proto,
                                        logic [15:0] port, logic [15:0] ulen,
                                        int pay, int total);
        int ubase;
        int n;
        ubase = ETH_HDR_BYTES + ihl * 4;
        n     = (total > 0) ? total : ubase + UDP_HDR_BYTES + pay;
        frame_q.delete();
        repeat (n) frame_q.push_back(8'($urandom));
        put_byte(12, etype[15:8]);
        put_byte(13, etype[7:0]);
        put_byte(ETH_HDR_BYTES, {4'($urandom), 4'(ihl)});
        put_byte(ubase + 2, port[15:8]);
        put_byte(ubase + 3, port[7:0]);
        put_byte(ubase + 4, ulen[15:8]);
        put_byte(ubase + 5, ulen[7:0]);
        put_byte(POS_IP_PROTO, proto);
    endfunction

    // every driving task starts on a falling edge and returns just after a rising one
    task automatic send_frame();
        bytes_sent += frame_q.size();
        for (int i = 0; i < frame_q.size(); i++) begin
            @(negedge aclk);
            while (take_gap()) begin
                s_tvalid = 1'b0;
                @(negedge aclk);
            end
            s_tvalid = 1'b1;
            s_tdata  = frame_q[i];
            s_tlast  = (i == frame_q.size() - 1);
            do @(posedge aclk); while (!s_tready);
        end
    endtask

    task automatic send_fields(logic [15:0] etype, int ihl, logic [7:0] proto,
                               logic [15:0] port, logic [15:0] ulen, int pay, int total);
        build_frame(etype, ihl, proto, port, ulen, pay, total);
        send_frame();
    endtask

    task automatic apb_write(logic reg_sel, logic [APB_DATA_W-1:0] value);
        @(negedge aclk);
        s_tvalid = 1'b0;
        psel     = 1'b1;
        penable  = 1'b0;
        pwrite   = 1'b1;
        paddr    = {reg_sel, 2'b00};
        pwdata   = value;
        @(negedge aclk);
        penable  = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        @(posedge aclk);
    endtask

    // hold the input until every message is out, then let the pipeline settle
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (chars_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic set_port(logic [15:0] port, logic [15:0] upper);
        cur_port = port;
        apb_write(REG_MATCH_PORT, {upper, port});
    endtask

    // short frames: a zero IHL puts the UDP header straight after the Ethernet header
    task automatic make_random_frame();
        int          kind;
        int          ihl;
        int          pay;
        int          total;
        int          bit_sel;
        logic [15:0] etype;
        logic [15:0] port;
        logic [15:0] ulen;
        logic [7:0]  proto;
        kind    = $urandom_range(0, 99);
        ihl     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        pay     = $urandom_range(0, 6);
        bit_sel = $urandom_range(0, 15);
        etype   = ETHERTYPE_IPV4;
        proto   = IP_PROTO_UDP;
        port    = ($urandom_range(0, 9) == 0) ? 16'($urandom) : cur_port;
        ulen    = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 20)) : 16'(pay + 8);
        total   = 0;
        if ($urandom_range(0, 2) == 0)
            total = ETH_HDR_BYTES + ihl * 4 + UDP_HDR_BYTES + pay + $urandom_range(1, 3);
        if (kind >= 70 && kind < 85) begin
            case ($urandom_range(0, 3))
                0:       etype = 16'($urandom);
                1:       proto = 8'($urandom);
                2:       etype[bit_sel] = ~etype[bit_sel];
                default: total = $urandom_range(1, ETH_HDR_BYTES + ihl * 4 + 8 + pay);
            endcase
        end
        build_frame(etype, ihl, proto, port, ulen, pay, total);
        if (kind >= 85) begin
            frame_q.delete();
            repeat ($urandom_range(1, 24)) frame_q.push_back(8'($urandom));
        end
    endtask

    initial begin
        logic en;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cur_port = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(posedge aclk);

        // capture still disabled from reset: a matching frame is dropped
        send_fields(ETHERTYPE_IPV4, 0, IP_PROTO_UDP, 16'h0000, 16'd10, 2, 0);
        wait_drained();
        set_port(16'h1234, 16'h0000);
        apb_write(REG_CAPTURE_EN, 32'd1);

        send_fields(ETHERTYPE_IPV4, 0, IP_PROTO_UDP, cur_port, 16'd12, 4, 0);
        // short UDP length blanks the whole message
        send_fields(ETHERTYPE_IPV4, 0, IP_PROTO_UDP, cur_port, 16'd4, 2, 0);

        for (int n = 0; bytes_sent < ITEM_TARGET; n++) begin
            if (n == 2) begin
                wait_drained();
                case ($urandom_range(0, 3))
                    0:       set_port(16'h0000, 16'($urandom));
                    1:       set_port(16'hFFFF, 16'($urandom));
                    default: set_port(16'($urandom), 16'($urandom));
                endcase
                en = ($urandom_range(0, 4) != 0);
                apb_write(REG_CAPTURE_EN, {31'($urandom), en});
            end
            steady_flow = (n < 2);
            make_random_frame();
            send_frame();
        end
        steady_flow = 1'b0;

        wait_drained();
        if (mismatches == 0 && chars_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/udppx_pkg.sv
hdl/udp_port_payload_extractor_unit.sv
hdl/udppx_checker.sv
test/udp_payload_checker.sv
test/testbench.sv
